@@ src/semaphore_wait_queue_with_tokens_assert.svh @@
// Assertion macros for the semaphore wait queue.
// Used by the top level; no other dependencies.
`ifndef SEMAPHORE_WAIT_QUEUE_WITH_TOKENS_ASSERT_SVH
`define SEMAPHORE_WAIT_QUEUE_WITH_TOKENS_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define SWQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication: post is checked in the cycle after pre holds.
`define SWQ_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ src/swq_pkg.sv @@
// Package for the semaphore wait queue: sizes, request kinds, error codes, states, cell control, saturating add.
// No dependencies.
package swq_pkg;
    localparam int NUM_TASKS_DEF   = 8;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int EW = 8;

    typedef enum logic [2:0] {
        K_WAIT = 3'd0, K_SIGNAL = 3'd1, K_START = 3'd2,
        K_CONT = 3'd3, K_FINISH = 3'd4, K_ABORT = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        E_NONE = 2'd0, E_FULL = 2'd1, E_INVALID = 2'd2, E_NOT_READY = 2'd3
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_SHIFT, S_SIGNAL, S_OUT
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic       shift;      // slots in [rm_pos, tail_last) load the next slot's entry (toward head)
        logic [6:0] rm_pos;
        logic [6:0] head;
        logic [6:0] tail_last;  // last occupied slot
        logic       wr;
        logic [6:0] wr_idx;
        logic [EW-1:0] wr_data;
    } t_cell_ctl;

    function automatic logic signed [7:0] sat_add(input logic signed [7:0] a,
                                                   input logic signed [1:0] d);
        logic signed [8:0] s;
        s = {a[7], a} + {{7{d[1]}}, d};
        if (s > 9'sd127) return 8'sd127;
        if (s < -9'sd128) return -8'sd128;
        return s[7:0];
    endfunction
endpackage

@@ src/swq_cell.sv @@
// One queue slot: holds an entry, compares it to the key, shifts from its neighbor.
// Depends on swq_pkg.
module swq_cell import swq_pkg::*; #(
    parameter int IDX = 0,
    parameter int QD  = QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  t_cell_ctl     i_ctl,
    input  logic [EW-1:0] i_next,
    input  logic [EW-1:0] i_key,
    output logic [EW-1:0] o_entry,
    output logic          o_match
);
    localparam logic [6:0] MY = 7'(IDX);
    logic [EW-1:0] r_entry;
    logic          moving;

    // a slot moves when it lies in the circular range [rm_pos, tail_last)
    always_comb begin
        if (i_ctl.rm_pos <= i_ctl.tail_last)
            moving = (MY >= i_ctl.rm_pos) && (MY < i_ctl.tail_last);
        else
            moving = (MY >= i_ctl.rm_pos) || (MY < i_ctl.tail_last);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr && i_ctl.wr_idx == MY)
            r_entry <= i_ctl.wr_data;
        else if (i_ctl.shift && moving)
            r_entry <= i_next;
    end

    assign o_entry = r_entry;
    assign o_match = (r_entry == i_key);
endmodule

@@ src/semaphore_wait_queue_with_tokens.sv @@
// Steps: wait and start_wait go through scan and output, signal adds a signal step;
// continue, finish and abort scan one slot per cycle, then finish and abort may shift and
// abort signals (search, shift in one step across the cell row, signal). One request at
// a time; the next transfer is taken in the cycle after the result register loads, later
// while the result is stalled. Reset: synchronous active-low; count and ready count load 1,
// queue empty, token counter NUM_TASKS. Queue slots are not cleared.
module semaphore_wait_queue_with_tokens import swq_pkg::*; #(
    parameter int NUM_TASKS   = NUM_TASKS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // kind[2:0], task_id[5:3], token_in[13:6]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // block_caller, resume_valid, resume_id[9:2],
                                       // new_token[17:10], ready_hit[18], error[20:19]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    localparam int         AW = $clog2(QUEUE_DEPTH);
    localparam logic [6:0] QM = 7'(QUEUE_DEPTH - 1);
    localparam logic [7:0] NT = 8'(NUM_TASKS);

    t_state r_st, n_st;
    logic signed [7:0] r_units, n_units, r_ready, n_ready;
    logic [6:0] r_head, n_head, r_tail, n_tail;
    logic [7:0] r_tok, n_tok;
    logic [6:0] r_pos, n_pos;
    logic [6:0] r_rm, n_rm;
    logic [2:0] r_kind;
    logic [2:0] r_tid;
    logic [7:0] r_key;
    logic       r_rdy_hit, n_rdy_hit;
    logic [1:0] r_err, n_err;
    logic       r_blk, n_blk, r_rv, n_rv;
    logic [7:0] r_rid, n_rid, r_nt, n_nt;
    logic       r_ov;
    logic [23:0] r_od;
    t_cell_ctl  ctl;
    logic [EW-1:0] ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] mt;

    function automatic logic [6:0] inc(input logic [6:0] x);
        return (x == QM) ? 7'd0 : x + 7'd1;
    endfunction
    function automatic logic [6:0] dec(input logic [6:0] x);
        return (x == 7'd0) ? QM : x - 7'd1;
    endfunction

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            swq_cell #(.IDX(g), .QD(QUEUE_DEPTH)) u_cell (
                .i_clk(i_clk), .i_ctl(ctl),
                .i_next(ent[(g + 1) % QUEUE_DEPTH]), .i_key(r_key),
                .o_entry(ent[g]), .o_match(mt[g]));
        end
    endgenerate

    logic [6:0] occ, cur;
    logic       full, cur_hit, head_hit;
    logic [EW-1:0] head_e;
    assign occ  = (r_tail >= r_head) ? r_tail - r_head : r_tail + 7'(QUEUE_DEPTH) - r_head;
    assign full = (inc(r_tail) == r_head);
    assign cur  = (r_head + r_pos >= 7'(QUEUE_DEPTH)) ? r_head + r_pos - 7'(QUEUE_DEPTH)
                                                     : r_head + r_pos;
    assign cur_hit  = mt[cur[AW-1:0]];
    assign head_e   = ent[r_head[AW-1:0]];
    assign head_hit = mt[r_head[AW-1:0]];

    assign s_axis_tready = (r_st == S_IDLE);
    // take a config write only when no request transfer can happen in the same cycle
    assign o_cfg_ready   = (r_st == S_IDLE) && !r_ov && !s_axis_tvalid;

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            S_IDLE: if (s_axis_tvalid) n_st = S_SCAN;
            S_SCAN: begin
                if (r_kind == K_CONT || r_kind == K_FINISH || r_kind == K_ABORT) begin
                    if (r_key < NT) n_st = S_OUT;
                    else if (r_kind != K_CONT && occ != 0 && r_pos == 0 && head_hit)
                        n_st = (r_kind == K_ABORT) ? S_SIGNAL : S_OUT;
                    else if (r_pos >= occ) n_st = S_OUT;
                    else if (r_kind == K_CONT &&
                             ($signed({1'b0, r_pos}) >= r_ready)) n_st = S_OUT;
                    else if (cur_hit)
                        n_st = (r_kind == K_CONT) ? S_OUT : S_SHIFT;
                end else if (r_kind == K_SIGNAL) n_st = S_SIGNAL;
                else n_st = S_OUT;
            end
            S_SHIFT:  n_st = (r_kind == K_ABORT) ? S_SIGNAL : S_OUT;
            S_SIGNAL: n_st = S_OUT;
            S_OUT:    if (!r_ov || m_axis_tready) n_st = S_IDLE;
            default:  n_st = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic ready_rm;
        n_units = r_units; n_ready = r_ready; n_head = r_head; n_tail = r_tail;
        n_tok = r_tok; n_pos = r_pos; n_rm = r_rm; n_rdy_hit = r_rdy_hit;
        n_err = r_err; n_blk = r_blk; n_rv = r_rv; n_rid = r_rid; n_nt = r_nt;
        ctl = '0;
        ctl.rm_pos = r_rm; ctl.head = r_head; ctl.tail_last = dec(r_tail);
        ctl.wr_idx = r_tail; ctl.wr_data = {5'd0, r_tid};
        ready_rm = 1'b0;
        case (r_st)
            S_IDLE: begin
                n_pos = '0; n_rdy_hit = 0; n_err = E_NONE; n_blk = 0; n_rv = 0;
                n_rid = '0; n_nt = '0;
            end
            S_SCAN: begin
                case (r_kind)
                    K_WAIT: begin
                        if (sat_add(r_units, -2'sd1) < 0) begin
                            if (full) n_err = E_FULL;
                            else begin
                                ctl.wr = 1'b1; n_tail = inc(r_tail);
                                n_units = sat_add(r_units, -2'sd1); n_blk = 1'b1;
                            end
                        end else begin
                            n_units = sat_add(r_units, -2'sd1);
                            n_ready = sat_add(r_ready, -2'sd1);
                        end
                    end
                    K_START: begin
                        if (full) n_err = E_FULL;
                        else begin
                            ctl.wr = 1'b1; ctl.wr_data = r_tok; n_tail = inc(r_tail);
                            n_tok = (r_tok == 8'hFF) ? NT : r_tok + 8'd1;
                            n_units = sat_add(r_units, -2'sd1); n_nt = r_tok;
                        end
                    end
                    K_CONT, K_FINISH, K_ABORT: begin
                        if (r_key < NT) n_err = E_INVALID;
                        else if (r_kind != K_CONT && occ != 0 && r_pos == 0 && head_hit) begin
                            n_head = inc(r_head); n_ready = sat_add(r_ready, -2'sd1);
                            n_rdy_hit = 1'b1;
                        end else if (r_pos >= occ) begin
                            if (r_kind != K_CONT) n_err = E_INVALID;
                        end else if (r_kind == K_CONT &&
                                     ($signed({1'b0, r_pos}) >= r_ready)) begin
                            n_err = E_NONE;
                        end else if (cur_hit) begin
                            if (r_kind == K_CONT) n_rdy_hit = 1'b1;
                            else n_rm = cur;
                        end else n_pos = r_pos + 7'd1;
                    end
                    default: ;
                endcase
            end
            S_SHIFT: begin
                ctl.shift = 1'b1; n_tail = dec(r_tail);
                ready_rm = (r_ready > 0) && ($signed({1'b0, r_pos}) < r_ready);
                if (ready_rm) begin
                    n_ready = sat_add(r_ready, -2'sd1); n_rdy_hit = 1'b1;
                end else if (r_kind == K_ABORT) n_ready = sat_add(r_ready, -2'sd1);
                else n_err = E_NOT_READY;
            end
            S_SIGNAL: begin
                n_units = sat_add(r_units, 2'sd1);
                n_ready = sat_add(r_ready, 2'sd1);
                if (occ != 0 && sat_add(r_ready, 2'sd1) > 0 && head_e < NT) begin
                    n_head = inc(r_head); n_rv = 1'b1; n_rid = head_e;
                    n_ready = sat_add(sat_add(r_ready, 2'sd1), -2'sd1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_units <= 8'sd1; r_ready <= 8'sd1;
            r_head <= '0; r_tail <= '0; r_tok <= NT; r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_units <= n_units; r_ready <= n_ready;
            r_head <= n_head; r_tail <= n_tail; r_tok <= n_tok;
            if (i_cfg_valid && o_cfg_ready) begin
                r_units <= $signed({1'b0, i_cfg_data});
                r_ready <= $signed({1'b0, i_cfg_data});
            end
            if (r_st == S_OUT && (!r_ov || m_axis_tready)) r_ov <= 1'b1;
            else if (m_axis_tready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos; r_rm <= n_rm; r_rdy_hit <= n_rdy_hit; r_err <= n_err;
        r_blk <= n_blk; r_rv <= n_rv; r_rid <= n_rid; r_nt <= n_nt;
        if (r_st == S_IDLE && s_axis_tvalid) begin
            r_kind <= s_axis_tdata[2:0]; r_tid <= s_axis_tdata[5:3];
            r_key  <= s_axis_tdata[13:6];
        end
        if (r_st == S_OUT && (!r_ov || m_axis_tready))
            r_od <= {3'd0, r_err, r_rdy_hit, r_nt, r_rid, r_rv, r_blk};
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_od;

`include "semaphore_wait_queue_with_tokens_assert.svh"
    `SWQ_ASSERT(a_one_free, !(r_st == S_SCAN && full && n_tail != r_tail && n_head == r_head),
                "queue overfilled")
    `SWQ_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
                "result dropped")
    `SWQ_ASSERT(a_cfg_idle, !(o_cfg_ready && r_st != S_IDLE), "config outside idle")
endmodule
